>>> rtl/core/wpd_pkg.sv
// ----------------------------------------------------------------------------
// wpd_pkg
// Shared types and constants for the window peak detector.
// ----------------------------------------------------------------------------
`default_nettype none

package wpd_pkg;

    localparam int CFG_BITS            = 7;
    localparam int HALF_WINDOW_RESET   = 16;
    localparam int DEF_MAX_HALF_WINDOW = 64;
    localparam int DEF_SAMPLE_BITS     = 24;
    localparam int POS_BITS            = 32;

    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

    // controls broadcast to every cell of the delay line
    typedef struct packed {
        logic shift;    // take neighbor value
        logic clear;    // end of record, zero the cell
        logic compare;  // register greater-than flag against candidate
    } t_cell_ctrl;

endpackage

`default_nettype wire

>>> rtl/core/wpd_cell.sv
// ----------------------------------------------------------------------------
// wpd_cell
// One delay line cell: holds a sample, shifts it to the next cell and flags
// whether it beats the current peak candidate inside the window.
// ----------------------------------------------------------------------------
`default_nettype none

module wpd_cell #(
    parameter int SAMPLE_BITS = 24,
    parameter int SPAN_BITS   = 8,
    parameter int CELL_IDX    = 0
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire wpd_pkg::t_cell_ctrl        i_ctrl,
    input  wire logic [SPAN_BITS-1:0]       i_span,
    input  wire logic signed [SAMPLE_BITS-1:0] i_prev,
    input  wire logic signed [SAMPLE_BITS-1:0] i_cand,
    output logic signed [SAMPLE_BITS-1:0]   o_value,
    output logic                            o_greater
);
    import wpd_pkg::*;

    logic signed [SAMPLE_BITS-1:0] r_value;
    logic                          r_greater;
    logic                          in_window;

    assign in_window = SPAN_BITS'(CELL_IDX) < i_span;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_value <= '0;
        end else if (i_ctrl.shift) begin
            r_value <= i_prev;
        end
    end

    // the candidate cell never beats itself, so it needs no exclusion
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_greater <= 1'b0;
        end else if (i_ctrl.compare) begin
            r_greater <= in_window && (r_value > i_cand);
        end
    end

    assign o_value   = r_value;
    assign o_greater = r_greater;

endmodule

`default_nettype wire

>>> rtl/core/window_peak_detector.sv
// ----------------------------------------------------------------------------
// window_peak_detector
// Streams signed samples through a row of delay cells and reports local
// maxima. Sample i is a peak when nothing from i-W to i+W-1 is strictly
// greater; the verdict comes when sample i+W-1 is taken, with the 1-based
// position (saturating) and height. A sample marked last ends the record,
// gives no result and clears the counter and the delay line. An item that is
// tested passes through transfer, candidate select, parallel compare in every
// cell and flag reduction before the next sample is taken; an untested or last
// item needs only the transfer. A finished result waits in an output register
// while the next sample is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module window_peak_detector #(
    parameter int MAX_HALF_WINDOW = wpd_pkg::DEF_MAX_HALF_WINDOW,
    parameter int SAMPLE_BITS     = wpd_pkg::DEF_SAMPLE_BITS
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    output logic                                o_in_ready,
    input  wire logic signed [SAMPLE_BITS-1:0]  i_sample,
    input  wire                                 i_last_of_record,
    output logic                                o_out_valid,
    input  wire                                 i_out_ready,
    output logic [wpd_pkg::POS_BITS-1:0]        o_peak_position,
    output logic signed [SAMPLE_BITS-1:0]       o_peak_height,
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [wpd_pkg::CFG_BITS-1:0]   i_cfg_half_window
);
    import wpd_pkg::*;

    localparam int DEPTH     = 2 * MAX_HALF_WINDOW;
    localparam int IDX_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int W_BITS    = $clog2(MAX_HALF_WINDOW + 1);
    localparam int SPAN_BITS = W_BITS + 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SEL  = 2'd1;
    localparam logic [1:0] S_CMP  = 2'd2;
    localparam logic [1:0] S_RED  = 2'd3;

    logic [1:0]                    r_state, n_state;
    logic [CFG_BITS-1:0]           r_half_window;
    logic [POS_BITS-1:0]           r_count;
    logic [W_BITS-1:0]             r_w;
    logic [POS_BITS-1:0]           r_pos;
    logic signed [SAMPLE_BITS-1:0] r_cand;
    logic                          r_out_valid;
    logic [POS_BITS-1:0]           r_out_pos;
    logic signed [SAMPLE_BITS-1:0] r_out_height;

    logic                          in_xfer;
    logic [W_BITS-1:0]             w_eff;
    logic [SPAN_BITS-1:0]          span_eff;
    logic [SPAN_BITS-1:0]          span;
    logic                          do_test;
    logic [POS_BITS:0]             pos_wide;
    logic [POS_BITS-1:0]           pos_sat;
    logic [IDX_BITS-1:0]           cand_idx;
    logic                          any_greater;
    logic                          out_free;
    t_cell_ctrl                    cell_ctrl;

    logic signed [SAMPLE_BITS-1:0] cell_val [DEPTH];
    logic [DEPTH-1:0]              greater_vec;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_xfer     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;

    // clamp the half window into 1..MAX_HALF_WINDOW
    always_comb begin
        if (r_half_window == '0) begin
            w_eff = W_BITS'(1);
        end else if (32'(r_half_window) > 32'(MAX_HALF_WINDOW)) begin
            w_eff = W_BITS'(MAX_HALF_WINDOW);
        end else begin
            w_eff = W_BITS'(r_half_window);
        end
    end

    assign span_eff = {w_eff, 1'b0};
    assign span     = {r_w, 1'b0};
    // c >= 2W-1 written as c+1 >= 2W
    assign do_test  = ((POS_BITS+1)'(r_count) + (POS_BITS+1)'(1))
                      >= (POS_BITS+1)'(span_eff);
    assign pos_wide = (POS_BITS+1)'(r_count) + (POS_BITS+1)'(2)
                      - (POS_BITS+1)'(w_eff);
    assign pos_sat  = pos_wide[POS_BITS] ? POS_MAX : pos_wide[POS_BITS-1:0];
    assign cand_idx = IDX_BITS'(r_w - W_BITS'(1));
    assign any_greater = |greater_vec;

    always_comb begin
        cell_ctrl.shift   = in_xfer && !i_last_of_record;
        cell_ctrl.clear   = in_xfer && i_last_of_record;
        cell_ctrl.compare = (r_state == S_CMP);
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic signed [SAMPLE_BITS-1:0] prev;
            if (g == 0) begin : g_head
                assign prev = i_sample;
            end else begin : g_body
                assign prev = cell_val[g-1];
            end
            wpd_cell #(
                .SAMPLE_BITS (SAMPLE_BITS),
                .SPAN_BITS   (SPAN_BITS),
                .CELL_IDX    (g)
            ) u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctrl    (cell_ctrl),
                .i_span    (span),
                .i_prev    (prev),
                .i_cand    (r_cand),
                .o_value   (cell_val[g]),
                .o_greater (greater_vec[g])
            );
        end
    endgenerate

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer && !i_last_of_record && do_test) begin
                    n_state = S_SEL;
                end
            end
            S_SEL:  n_state = S_CMP;
            S_CMP:  n_state = S_RED;
            S_RED: begin
                if (any_greater || out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_half_window <= CFG_BITS'(HALF_WINDOW_RESET);
            r_count       <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_half_window <= i_cfg_half_window;
            end
            if (in_xfer) begin
                if (i_last_of_record) begin
                    r_count <= '0;
                end else if (r_count != POS_MAX) begin
                    r_count <= r_count + POS_BITS'(1);
                end
            end
        end
    end

    // per-item working registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_w   <= w_eff;
            r_pos <= pos_sat;
        end
        if (r_state == S_SEL) begin
            r_cand <= cell_val[cand_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_RED && !any_greater && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_RED && !any_greater && out_free) begin
            r_out_pos    <= r_pos;
            r_out_height <= r_cand;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_peak_position = r_out_pos;
    assign o_peak_height   = r_out_height;

endmodule

`default_nettype wire

>>> bench/tb_window_peak_detector.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_window_peak_detector
// Self-checking bench for the window peak detector. A queue-fed driver sends
// samples in bursts, a stalling receiver takes peaks, and a built-in predictor
// of the delay line and record counter checks every peak in order. The
// half-window is swept through its extremes, clamped values and a change in
// the middle of a record.
// ----------------------------------------------------------------------------

module tb_window_peak_detector;

    localparam int SB             = wpd_pkg::DEF_SAMPLE_BITS;
    localparam int MAX_HW         = wpd_pkg::DEF_MAX_HALF_WINDOW;
    localparam int LINE_DEPTH     = 2 * MAX_HW;
    localparam int CFG_BITS       = wpd_pkg::CFG_BITS;
    localparam int POS_BITS       = wpd_pkg::POS_BITS;
    localparam int SETTLE_CYCLES  = 10;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;

    localparam logic signed [SB-1:0] SAMPLE_MAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] SAMPLE_MIN = {1'b1, {(SB-1){1'b0}}};

    typedef struct {
        logic signed [SB-1:0] sample;
        logic                 last;
    } t_sample_item;

    typedef struct {
        logic [POS_BITS-1:0]  position;
        logic signed [SB-1:0] height;
    } t_peak;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_ready;
    logic signed [SB-1:0]       i_sample;
    logic                       i_last_of_record;
    logic                       o_out_valid;
    logic                       i_out_ready;
    logic [POS_BITS-1:0]        o_peak_position;
    logic signed [SB-1:0]       o_peak_height;
    logic                       i_cfg_valid;
    logic                       o_cfg_ready;
    logic [CFG_BITS-1:0]        i_cfg_half_window;

    // predictor state
    logic signed [SB-1:0]       delay_line [LINE_DEPTH];
    longint unsigned            rec_count;
    logic [CFG_BITS-1:0]        half_w;

    t_sample_item               sample_q [$];
    t_peak                      exp_peaks [$];
    t_peak                      want_pk;
    t_peak                      new_pk;

    t_sample_item               cur_item;
    logic                       in_xfer;
    int                         gap_left;
    int                         burst_left;
    int                         stall_mode;
    int                         stall_left;
    int                         stall_tick;
    int                         hold_left;
    bit                         hold_request;
    int                         quiet_cycles;

    int                         n_samples;
    int                         n_records;
    int                         n_peaks;
    int                         n_errors;
    int                         n_cfg_writes;
    int                         n_holds;

    window_peak_detector #(
        .MAX_HALF_WINDOW (MAX_HW),
        .SAMPLE_BITS     (SB)
    ) u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_sample          (i_sample),
        .i_last_of_record  (i_last_of_record),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_peak_position   (o_peak_position),
        .o_peak_height     (o_peak_height),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_half_window (i_cfg_half_window)
    );

    always #10 i_clk = ~i_clk;

    function automatic int eff_half_window(input logic [CFG_BITS-1:0] hw);
        if (hw == 0)
            return 1;
        if (hw > MAX_HW)
            return MAX_HW;
        return int'(hw);
    endfunction

    // advances the predicted delay line by one sample (a last sample clears it instead), returns 1 on a peak
    function automatic bit predict_peak(input logic signed [SB-1:0] smp, input logic last,
                                        output t_peak pk);
        int                   w;
        int                   d;
        bit                   hit;
        longint unsigned      pos;
        logic signed [SB-1:0] cand;
        w = eff_half_window(half_w);
        hit = 1'b0;
        pk.position = '0;
        pk.height = '0;
        if (last) begin
            for (d = 0; d < LINE_DEPTH; d++)
                delay_line[d] = '0;
            rec_count = 0;
            return 1'b0;
        end
        for (d = LINE_DEPTH - 1; d > 0; d--)
            delay_line[d] = delay_line[d-1];
        delay_line[0] = smp;
        if (rec_count >= longint'(2 * w - 1)) begin
            cand = delay_line[w-1];
            hit = 1'b1;
            for (d = 0; d < 2 * w; d++) begin
                if (d != w - 1 && delay_line[d] > cand)
                    hit = 1'b0;
            end
            if (hit) begin
                pos = rec_count - longint'(w) + 2;
                if (pos > 64'hFFFF_FFFF)
                    pos = 64'hFFFF_FFFF;
                pk.position = pos[POS_BITS-1:0];
                pk.height = cand;
            end
        end
        if (rec_count < 64'hFFFF_FFFF)
            rec_count++;
        return hit;
    endfunction

    function automatic logic signed [SB-1:0] gen_sample(input int mode);
        int v;
        case (mode)
            0: v = int'($urandom);
            1: v = int'($urandom_range(0, 6)) - 3;            // narrow range, many ties
            2: v = ($urandom_range(0, 15) == 0) ? int'($urandom) : int'($urandom_range(0, 31));
            default: begin
                case ($urandom_range(0, 4))
                    0: v = int'(SAMPLE_MAX);
                    1: v = -(2 ** (SB - 1));
                    2: v = 0;
                    3: v = -1;
                    default: v = 1;
                endcase
            end
        endcase
        return v[SB-1:0];
    endfunction

    task automatic push_sample(input logic signed [SB-1:0] smp, input logic last);
        t_sample_item it;
        it.sample = smp;
        it.last = last;
        sample_q.push_back(it);
    endtask

    // block is idle: nothing queued or offered, no peak pending, pipeline drained
    task automatic wait_idle();
        while (sample_q.size() != 0 || i_in_valid || exp_peaks.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_half_window(input logic [CFG_BITS-1:0] hw);
        wait_idle();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_half_window <= hw;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        half_w = hw;
        n_cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // mostly complete records long enough to be tested, some short ones,
    // and the phase may end with its record still open
    task automatic run_random_phase(input logic [CFG_BITS-1:0] hw);
        int w;
        int budget;
        int pushed;
        int len;
        int mode;
        int k;
        write_half_window(hw);
        w = eff_half_window(hw);
        budget = (w <= 8) ? 40 : (w <= 16) ? 60 : 80;
        pushed = 0;
        while (pushed < budget) begin
            mode = $urandom_range(0, 3);
            if ($urandom_range(0, 9) < 8)
                len = $urandom_range(2 * w, 2 * w + 40);
            else
                len = $urandom_range(0, 2 * w - 1);
            for (k = 0; k < len; k++)
                push_sample(gen_sample(mode), 1'b0);
            pushed += len;
            if (pushed < budget || $urandom_range(0, 1) == 1) begin
                push_sample(gen_sample(0), 1'b1);
                pushed++;
            end
        end
    endtask

    // sender: bursts of random length with random gaps
    always @(negedge i_clk) begin
        if (!i_in_valid || in_xfer) begin
            if (gap_left > 0 || sample_q.size() == 0) begin
                i_in_valid <= 1'b0;
                if (gap_left > 0)
                    gap_left--;
            end else begin
                cur_item = sample_q.pop_front();
                i_in_valid <= 1'b1;
                i_sample <= cur_item.sample;
                i_last_of_record <= cur_item.last;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    // receiver: stall pattern whose mode is changed at random,
    // plus one long hold-off on request
    always @(negedge i_clk) begin
        stall_tick++;
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (hold_request && o_out_valid) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
            n_holds++;
            i_out_ready <= 1'b0;
        end else begin
            if (stall_left <= 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(16, 80);
            end
            stall_left--;
            case (stall_mode)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= ($urandom_range(0, 1) == 1);
                2: i_out_ready <= (stall_tick % 4 == 0);
                default: i_out_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // monitor: check peaks against predictions, predict on every sample transfer
    always @(posedge i_clk) begin
        in_xfer <= i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                n_peaks++;
                if (exp_peaks.size() == 0) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display("ERROR: unexpected peak: position %0d height %0d",
                                 o_peak_position, o_peak_height);
                end else begin
                    want_pk = exp_peaks.pop_front();
                    if (want_pk.position !== o_peak_position ||
                        want_pk.height !== o_peak_height) begin
                        n_errors++;
                        if (n_errors <= MAX_REPORTS)
                            $display({"ERROR: peak mismatch: expected position %0d height %0d,",
                                      " got position %0d height %0d"},
                                     want_pk.position, want_pk.height,
                                     o_peak_position, o_peak_height);
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                n_samples++;
                if (i_last_of_record)
                    n_records++;
                if (predict_peak(i_sample, i_last_of_record, new_pk))
                    exp_peaks.push_back(new_pk);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("ERROR: no transfer for %0d cycles", quiet_cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_sample = '0;
        i_last_of_record = 1'b0;
        i_out_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_half_window = '0;
        in_xfer = 1'b0;
        gap_left = 0;
        burst_left = 0;
        stall_mode = 0;
        stall_left = 0;
        stall_tick = 0;
        hold_left = 0;
        hold_request = 1'b0;
        quiet_cycles = 0;
        n_samples = 0;
        n_records = 0;
        n_peaks = 0;
        n_errors = 0;
        n_cfg_writes = 0;
        n_holds = 0;
        for (int d = 0; d < LINE_DEPTH; d++)
            delay_line[d] = '0;
        rec_count = 0;
        half_w = CFG_BITS'(wpd_pkg::HALF_WINDOW_RESET);

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // zero half-window acts as one: extremes, ties, empty records
        write_half_window('0);
        push_sample('0, 1'b0);
        push_sample(SAMPLE_MAX, 1'b0);
        push_sample(SAMPLE_MIN, 1'b0);
        push_sample(SAMPLE_MIN, 1'b0);
        push_sample(SAMPLE_MAX, 1'b0);
        push_sample(SAMPLE_MAX, 1'b0);
        push_sample(SB'(-1), 1'b0);
        push_sample(SB'(1), 1'b0);
        push_sample(24'sh555555, 1'b1);
        push_sample(24'shAAAAAA, 1'b1);

        // half-window changed while a record is open
        write_half_window(7'd2);
        push_sample(SB'(1), 1'b0);
        push_sample(SB'(4), 1'b0);
        push_sample(SB'(2), 1'b0);
        push_sample(SB'(4), 1'b0);
        push_sample(SB'(3), 1'b0);
        push_sample(SB'(0), 1'b0);
        write_half_window(7'd1);
        push_sample(SB'(9), 1'b0);
        push_sample(SB'(0), 1'b0);
        push_sample(SB'(0), 1'b1);

        run_random_phase(7'd1);
        run_random_phase(7'd2);
        hold_request = 1'b1;
        run_random_phase(7'd3);
        run_random_phase(7'd5);
        run_random_phase(7'd8);
        run_random_phase(7'd16);
        run_random_phase(7'd33);
        run_random_phase(7'd64);
        run_random_phase(7'd127);
        run_random_phase(7'd0);

        wait_idle();

        $display("run covered %0d samples in %0d closed records, %0d peaks checked",
                 n_samples, n_records, n_peaks);
        $display("half-window written %0d times (zero to 127), %0d long receiver hold-off",
                 n_cfg_writes, n_holds);
        if (n_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
